FILE: src/u8d_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
package u8d_pkg;

    // Largest legal code point and the surrogate window.
    localparam logic [20:0] CP_MAX    = 21'h10FFFF;
    localparam logic [20:0] SURR_BASE = 21'h00D800;
    localparam logic [20:0] SURR_LAST = 21'h00DFFF;

    // Byte classes found by the front end.
    typedef enum logic [2:0] {
        K_ASCII   = 3'd0,
        K_LEAD2   = 3'd1,
        K_LEAD3   = 3'd2,
        K_LEAD4   = 3'd3,
        K_CONT    = 3'd4,
        K_INVALID = 3'd5
    } t_kind;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_LEAD = 3'd1,
        ST_BAD_CONT = 3'd2,
        ST_RANGE    = 3'd3,
        ST_SURR     = 3'd4,
        ST_TRUNC    = 3'd5
    } t_status;

    // One classified byte: its class, its payload bits (masked) and the end flag.
    typedef struct packed {
        t_kind      kind;
        logic [6:0] bits;
        logic       last;
    } t_item;

    // One result request.
    typedef struct packed {
        logic [20:0] code_point;
        t_status     status;
        logic        end_of_string;
    } t_result;

endpackage

FILE: src/u8d_queue.sv
// Small register-based first-in first-out queue.
module u8d_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    // Pointer advance with wrap at the queue depth.
    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);

endmodule

FILE: src/u8d_front.sv
// Front end: accepts bytes, classifies them and queues them for the back end.
module u8d_front
    import u8d_pkg::*;
#(
    parameter int Q_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_full,
    output t_item      o_item,
    output logic       o_valid,
    input  logic       i_take
);

    t_item w_cls;
    logic  w_empty;
    logic  w_full;

    // Classify the byte and keep only the payload bits of its class.
    always_comb begin
        w_cls.last = i_last_byte;
        priority if (i_data_byte[7] == 1'b0) begin
            w_cls.kind = K_ASCII;
            w_cls.bits = i_data_byte[6:0];
        end else if (i_data_byte[6] == 1'b0) begin
            w_cls.kind = K_CONT;
            w_cls.bits = {1'b0, i_data_byte[5:0]};
        end else if (i_data_byte[5] == 1'b0) begin
            w_cls.kind = K_LEAD2;
            w_cls.bits = {2'b0, i_data_byte[4:0]};
        end else if (i_data_byte[4] == 1'b0) begin
            w_cls.kind = K_LEAD3;
            w_cls.bits = {3'b0, i_data_byte[3:0]};
        end else if (i_data_byte[3] == 1'b0) begin
            w_cls.kind = K_LEAD4;
            w_cls.bits = {4'b0, i_data_byte[2:0]};
        end else begin
            w_cls.kind = K_INVALID;
            w_cls.bits = '0;
        end
    end

    // Queue between the front and back ends.
    u8d_queue #(
        .WIDTH ($bits(t_item)),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && !w_full),
        .i_wdata (w_cls),
        .i_pop   (i_take),
        .o_rdata (o_item),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    assign o_full  = w_full;
    assign o_valid = !w_empty;

endmodule

FILE: src/u8d_back.sv
// Back end: assembles code points, checks them and queues the results.
module u8d_back
    import u8d_pkg::*;
#(
    parameter int OUT_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cesu_mode,
    input  t_item       i_item,
    input  logic        i_valid,
    output logic        o_take,
    input  logic        i_pop,
    output t_result     o_result,
    output logic        o_empty
);

    logic [20:0] r_acc, n_acc;
    logic [1:0]  r_rem, n_rem;
    logic        r_disc, n_disc;

    logic        w_out_full;
    logic        w_out_empty;
    logic        w_out_pop;
    logic        w_take;
    logic        w_res_valid;
    t_result     w_res;
    logic [20:0] w_cont_acc;
    logic [1:0]  w_cont_rem;

    assign w_out_pop = i_pop && !w_out_empty;
    // An item is taken when the result queue has room, counting a pop this cycle.
    assign w_take    = i_valid && (!w_out_full || w_out_pop);
    assign o_take    = w_take;

    // Continuation step: shift in six more bits.
    assign w_cont_acc = {r_acc[14:0], i_item.bits[5:0]};
    assign w_cont_rem = r_rem - 1'b1;

    // Sequence state and result selection.
    always_comb begin
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_disc      = r_disc;
        w_res_valid = 1'b0;
        w_res       = '{code_point: '0, status: ST_OK, end_of_string: i_item.last};
        if (w_take) begin
            if (r_disc) begin
                if (i_item.last) begin
                    n_disc = 1'b0;
                    n_acc  = '0;
                    n_rem  = '0;
                end
            end else if (r_rem == 2'd0) begin
                unique case (i_item.kind)
                    K_ASCII: begin
                        w_res_valid      = 1'b1;
                        w_res.code_point = {14'b0, i_item.bits};
                    end
                    K_LEAD2, K_LEAD3, K_LEAD4: begin
                        if (i_item.last) begin
                            w_res_valid  = 1'b1;
                            w_res.status = ST_TRUNC;
                        end else begin
                            n_acc = {14'b0, i_item.bits};
                            n_rem = (i_item.kind == K_LEAD2) ? 2'd1 :
                                    (i_item.kind == K_LEAD3) ? 2'd2 : 2'd3;
                        end
                    end
                    default: begin
                        w_res_valid  = 1'b1;
                        w_res.status = ST_BAD_LEAD;
                    end
                endcase
            end else if (i_item.kind != K_CONT) begin
                w_res_valid  = 1'b1;
                w_res.status = ST_BAD_CONT;
            end else if (w_cont_rem != 2'd0) begin
                if (i_item.last) begin
                    w_res_valid  = 1'b1;
                    w_res.status = ST_TRUNC;
                end else begin
                    n_acc = w_cont_acc;
                    n_rem = w_cont_rem;
                end
            end else begin
                w_res_valid = 1'b1;
                priority if (w_cont_acc > CP_MAX) begin
                    w_res.status = ST_RANGE;
                end else if (!i_cesu_mode && w_cont_acc >= SURR_BASE
                             && w_cont_acc <= SURR_LAST) begin
                    w_res.status = ST_SURR;
                end else begin
                    w_res.code_point = w_cont_acc;
                end
            end
        end
        // Every result ends the sequence; an early error drops the rest of the string.
        if (w_res_valid) begin
            n_acc  = '0;
            n_rem  = '0;
            n_disc = (w_res.status != ST_OK) && !i_item.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_rem  <= '0;
            r_disc <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_rem  <= n_rem;
            r_disc <= n_disc;
        end
    end

    // Result queue facing the consumer.
    u8d_queue #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_wdata (w_res),
        .i_pop   (w_out_pop),
        .o_rdata (o_result),
        .o_full  (w_out_full),
        .o_empty (w_out_empty)
    );

    assign o_empty = w_out_empty;

endmodule

FILE: src/utf8_stream_decoder_core.sv
// UTF-8 stream decoder top level: configuration register and front/back ends.
// Bytes go in through push/full and decoded code points come out through
// empty/pop, at a sustained rate of one byte per clock while the result
// queue has room. A byte is classified and written into the input queue at
// the edge where it is accepted; the back end takes the queue head when the
// result queue has room and writes its result there; the result queue head
// drives the outputs. Bytes that leave a sequence open give no result.
// Errors are reported as results with code point 0; after an error the rest
// of the string is dropped up to its last byte. Either queue lets its side
// stall on its own; when the result queue stays full the input queue fills
// and full rises. Write cesu_mode only while no request is in flight.
module utf8_stream_decoder_core
    import u8d_pkg::*;
#(
    parameter int Q_DEPTH   = 2,
    parameter int OUT_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [20:0] o_code_point,
    output logic [2:0]  o_status,
    output logic        o_end_of_string
);

    logic    r_cesu_mode;
    t_item   w_item;
    logic    w_valid;
    logic    w_take;
    t_result w_result;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cesu_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_cesu_mode <= i_cfg_wr_data;
        end
    end

    // Byte classification and input queue.
    u8d_front #(
        .Q_DEPTH (Q_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_full      (full),
        .o_item      (w_item),
        .o_valid     (w_valid),
        .i_take      (w_take)
    );

    // Sequence assembly, checks and result queue.
    u8d_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cesu_mode (r_cesu_mode),
        .i_item      (w_item),
        .i_valid     (w_valid),
        .o_take      (w_take),
        .i_pop       (pop),
        .o_result    (w_result),
        .o_empty     (empty)
    );

    assign o_code_point    = w_result.code_point;
    assign o_status        = w_result.status;
    assign o_end_of_string = w_result.end_of_string;

endmodule

FILE: test/tb.sv
// Self-checking testbench for the UTF-8 stream decoder core.
`timescale 1ns / 100ps

module tb
    import u8d_pkg::*;
();

    // One row of the directed stimulus; typed rows carry their own expected result.
    typedef struct {
        logic [7:0]  b;
        logic        l;
        bit          typed;
        bit          has_res;
        logic [20:0] cp;
        t_status     st;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_wr_data = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [20:0] o_code_point;
    logic [2:0]  o_status;
    logic        o_end_of_string;

    // Decoder state as the predictor sees it.
    logic [20:0] acc_bits = '0;
    logic [1:0]  conts_left = '0;
    logic        dropping = 1'b0;
    logic        cesu_en = 1'b0;

    t_result     pending_results[$];
    int unsigned mismatches = 0;
    int unsigned sent_bytes = 0;
    int unsigned tx_gap_pct = 0;
    int unsigned rx_stall_pct = 0;

    // Phase plan: register value, sender gap and receiver stall percentages.
    bit          phase_cesu [4] = '{1'b0, 1'b1, 1'b1, 1'b0};
    int unsigned phase_tx   [4] = '{19, 62, 0, 0};
    int unsigned phase_rx   [4] = '{62, 19, 0, 0};

    // Directed strings: extremes, every status code and the dropping rules.
    t_stim_row directed_rows [0:25] = '{
        '{8'h00, 1'b1, 1'b1, 1'b1, 21'h000000, ST_OK},
        '{8'h7F, 1'b0, 1'b1, 1'b1, 21'h00007F, ST_OK},
        '{8'h80, 1'b0, 1'b1, 1'b1, 21'h000000, ST_BAD_LEAD},
        '{8'h41, 1'b1, 1'b1, 1'b0, 21'h000000, ST_OK},
        '{8'hFF, 1'b1, 1'b1, 1'b1, 21'h000000, ST_BAD_LEAD},
        '{8'hC3, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
        '{8'hA9, 1'b1, 1'b0, 1'b0, 21'h000000, ST_OK},
        '{8'hE2, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
        '{8'h82, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
        '{8'hAC, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
        '{8'hF4, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
        '{8'h8F, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
        '{8'hBF, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
        '{8'hBF, 1'b1, 1'b0, 1'b0, 21'h000000, ST_OK},
        '{8'hF7, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
        '{8'hBF, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
        '{8'hBF, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
        '{8'hBF, 1'b1, 1'b1, 1'b1, 21'h000000, ST_RANGE},
        '{8'hED, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
        '{8'hA0, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
        '{8'h80, 1'b1, 1'b1, 1'b1, 21'h000000, ST_SURR},
        '{8'hC2, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
        '{8'h41, 1'b1, 1'b1, 1'b1, 21'h000000, ST_BAD_CONT},
        '{8'hE0, 1'b1, 1'b1, 1'b1, 21'h000000, ST_TRUNC},
        '{8'hF0, 1'b0, 1'b0, 1'b0, 21'h000000, ST_OK},
        '{8'h90, 1'b1, 1'b1, 1'b1, 21'h000000, ST_TRUNC}
    };

    utf8_stream_decoder_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .push            (push),
        .full            (full),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .empty           (empty),
        .pop             (pop),
        .o_code_point    (o_code_point),
        .o_status        (o_status),
        .o_end_of_string (o_end_of_string)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Prints one line per mismatch and counts them all.
    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Advances the decoder state by one byte and yields the result it causes, if any.
    task automatic decode_byte(input logic [7:0] b, input logic l,
                               output bit got, output t_result res);
        logic [20:0] cp;
        t_status     st;
        got = 1'b0;
        res = '0;
        cp = '0;
        st = ST_OK;
        if (dropping) begin
            // Bytes after an error are swallowed until the string ends.
            if (l) begin
                dropping = 1'b0;
                acc_bits = '0;
                conts_left = '0;
            end
            return;
        end
        if (conts_left == 2'd0) begin
            if (b < 8'h80) begin
                got = 1'b1;
                cp = {13'd0, b};
            end else if (b < 8'hC0 || b >= 8'hF8) begin
                got = 1'b1;
                st = ST_BAD_LEAD;
            end else if (l) begin
                got = 1'b1;
                st = ST_TRUNC;
            end else if (b < 8'hE0) begin
                acc_bits = {16'd0, b[4:0]};
                conts_left = 2'd1;
            end else if (b < 8'hF0) begin
                acc_bits = {17'd0, b[3:0]};
                conts_left = 2'd2;
            end else begin
                acc_bits = {18'd0, b[2:0]};
                conts_left = 2'd3;
            end
        end else if (b[7:6] != 2'b10) begin
            got = 1'b1;
            st = ST_BAD_CONT;
        end else begin
            acc_bits = {acc_bits[14:0], b[5:0]};
            conts_left = conts_left - 2'd1;
            if (conts_left != 2'd0) begin
                if (l) begin
                    got = 1'b1;
                    st = ST_TRUNC;
                end
            end else begin
                // Sequence complete: range first, then the surrogate window.
                got = 1'b1;
                if (acc_bits > CP_MAX) begin
                    st = ST_RANGE;
                end else if (!cesu_en && acc_bits >= SURR_BASE && acc_bits <= SURR_LAST) begin
                    st = ST_SURR;
                end else begin
                    cp = acc_bits;
                end
            end
        end
        if (got) begin
            res.code_point = cp;
            res.status = st;
            res.end_of_string = l;
            acc_bits = '0;
            conts_left = '0;
            dropping = (st != ST_OK) && !l;
        end
    endtask

    // Offers one byte request with random gaps and predicts it once accepted.
    task automatic send_byte(input logic [7:0] b, input logic l,
                             output bit got, output t_result res);
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= l;
        do @(posedge i_clk); while (full);
        decode_byte(b, l, got, res);
    endtask

    // Writes the mode register while the decoder is idle.
    task automatic write_cesu(input logic v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cesu_en = v;
    endtask

    // One random unit: mostly well-formed sequences, some broken ones, some noise.
    task automatic send_random_unit();
        logic [7:0] seq [4];
        int         len;
        int         roll;
        logic       l;
        bit         got;
        t_result    res;
        roll = $urandom_range(0, 99);
        len = $urandom_range(1, 4);
        for (int i = 0; i < 4; i++) begin
            seq[i] = 8'h80 | 8'($urandom_range(0, 63));
        end
        case (len)
            1: seq[0] = 8'($urandom_range(0, 127));
            2: seq[0] = 8'($urandom_range(8'hC0, 8'hDF));
            3: begin
                // Steer a share of three-byte sequences into the surrogate window.
                if ($urandom_range(0, 3) == 0) begin
                    seq[0] = 8'hED;
                    seq[1] = 8'hA0 | 8'($urandom_range(0, 31));
                end else begin
                    seq[0] = 8'($urandom_range(8'hE0, 8'hEF));
                end
            end
            default: begin
                // F4 straddles the top of the code space.
                if ($urandom_range(0, 2) == 0) begin
                    seq[0] = 8'hF4;
                end else begin
                    seq[0] = 8'($urandom_range(8'hF0, 8'hF7));
                end
            end
        endcase
        if (roll >= 70 && roll < 88) begin
            seq[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
        end else if (roll >= 88) begin
            len = 1;
            seq[0] = 8'($urandom_range(0, 255));
        end
        for (int i = 0; i < len; i++) begin
            l = (i == len - 1) ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 24) == 0);
            send_byte(seq[i], l, got, res);
            if (got) begin
                pending_results.push_back(res);
            end
            sent_bytes++;
        end
    endtask

    // Lets the decoder go quiet: all results back, then a wait for bytes that
    // cause no result.
    task automatic drain();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Result side: random stalls and a field-by-field check of every accepted result.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result cp=%h status=%0d end=%0b",
                                          o_code_point, o_status, o_end_of_string));
            end else begin
                want = pending_results.pop_front();
                if (o_code_point !== want.code_point) begin
                    report_mismatch($sformatf("code_point %h, expected %h",
                                              o_code_point, want.code_point));
                end
                if (o_status !== want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, want.status));
                end
                if (o_end_of_string !== want.end_of_string) begin
                    report_mismatch($sformatf("end_of_string %0b, expected %0b",
                                              o_end_of_string, want.end_of_string));
                end
            end
        end
        pop <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Main sequence: reset, then four phases of register setting and stimulus.
    initial begin
        bit      got;
        t_result res;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < 4; p++) begin
            tx_gap_pct = phase_tx[p];
            rx_stall_pct = phase_rx[p];
            write_cesu(phase_cesu[p]);
            if (p == 0) begin
                foreach (directed_rows[r]) begin
                    send_byte(directed_rows[r].b, directed_rows[r].l, got, res);
                    if (directed_rows[r].typed) begin
                        if (directed_rows[r].has_res) begin
                            res.code_point = directed_rows[r].cp;
                            res.status = directed_rows[r].st;
                            res.end_of_string = directed_rows[r].l;
                            pending_results.push_back(res);
                        end
                    end else if (got) begin
                        pending_results.push_back(res);
                    end
                end
            end
            sent_bytes = 0;
            while (sent_bytes < 160) send_random_unit();
            drain();
        end
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end
        if (mismatches == 0) begin
            $display("utf8_stream_decoder_core verification clean");
        end else begin
            $display("utf8_stream_decoder_core verification failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("utf8_stream_decoder_core verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
src/u8d_pkg.sv
src/u8d_queue.sv
src/u8d_front.sv
src/u8d_back.sv
src/utf8_stream_decoder_core.sv
test/tb.sv
